/* design/sine_dac_sample_generator_macros.svh */
// ----------------------------------------------------------------------------
// sine_dac_sample_generator_macros.svh
// Assertion macros used by the checker file of the sine DAC generator.
// ----------------------------------------------------------------------------
`ifndef SINE_DAC_SAMPLE_GENERATOR_MACROS_SVH
`define SINE_DAC_SAMPLE_GENERATOR_MACROS_SVH

// Same-cycle implication, masked during reset
`define SDSG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdsg: implication check failed");

// Implication with a fixed delay in cycles, masked during reset
`define SDSG_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("sdsg: delayed check failed");

`endif

/* design/sdsg_pkg.sv */
// ----------------------------------------------------------------------------
// sdsg_pkg
// Types, constants and the quarter-wave sine builder for the DAC generator.
// ----------------------------------------------------------------------------
package sdsg_pkg;

    localparam int TABLE_LEN       = 512;
    localparam int QUARTER_ENTRIES = 256;
    localparam int TBL_SHIFT       = $clog2(TABLE_LEN);
    localparam int QBITS           = $clog2(QUARTER_ENTRIES);
    localparam int ROM_AW          = QBITS + 1;

    localparam int IDX_W   = 10;
    localparam int FREQ_W  = 24;
    localparam int PHASE_W = 16;
    localparam int AMP_W   = 13;
    localparam int CODE_W  = 12;
    localparam int PROD_W  = IDX_W + FREQ_W;
    localparam int SINE_W  = 15;
    localparam int V_W     = 16;
    localparam int Y_W     = V_W + AMP_W;
    localparam int Z_W     = Y_W + 12;
    localparam int X_W     = 24;
    localparam int Q_W     = 14;
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W = 25;
    localparam int RP_W    = X_W + RECIP_W;
    localparam int LATENCY = 7;

    localparam logic [SINE_W-1:0] ONE_Q14   = 15'd16384;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
    localparam logic [RECIP_W-1:0] RECIP_825 = 25'd20824083;
    localparam logic [9:0]        DIV_825   = 10'd825;
    localparam logic [CODE_W-1:0] CODE_MAX  = 12'd4095;

    typedef enum logic [1:0] {
        REG_FREQ_STEP    = 2'd0,
        REG_PHASE_OFFSET = 2'd1,
        REG_AMPLITUDE_MV = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]       quad;
        logic [QBITS-1:0] k;
    } phase_t;

    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        int          n;
        if (k >= QUARTER_ENTRIES)
        begin
            return ONE_Q14;
        end
        a    = (64'(k) * HALF_PI_Q30) / 64'(QUARTER_ENTRIES);
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * a2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (64'(sum) + 64'd32768) >> 16;
        if (r > 64'(ONE_Q14))
        begin
            r = 64'(ONE_Q14);
        end
        return r[SINE_W-1:0];
    endfunction

endpackage

/* design/sine_dac_sample_generator.sv */
// ----------------------------------------------------------------------------
// sine_dac_sample_generator
// Sine sample to 12-bit DAC code generator, seven-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     start / busy           sample_index
//  result    done (strobe)          dac_code, clipped
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One sample enters per clock; each result passes through the pipeline
//  stages in order (multiply, phase, table, three scaling stages, output
//  register). busy stays low: the pipeline never fills up.
//  Reset clears the stage valid bits and loads the register defaults.
//  The receiver takes every done strobe, so nothing stalls.
// ----------------------------------------------------------------------------
module sine_dac_sample_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sdsg_pkg::IDX_W-1:0]   sample_index,
    output logic                         done,
    output logic [sdsg_pkg::CODE_W-1:0]  dac_code,
    output logic                         clipped,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [sdsg_pkg::FREQ_W-1:0]  cfg_data
);
    import sdsg_pkg::*;

    logic [FREQ_W-1:0]  freq_step_reg;
    logic [PHASE_W-1:0] phase_offset_reg;
    logic [AMP_W-1:0]   amplitude_mv_reg;
    logic               accept;
    logic               ph_valid;
    phase_t             ph_data;
    logic               lk_valid;
    logic [V_W-1:0]     lk_level;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg    <= FREQ_W'(65536);
            phase_offset_reg <= '0;
            amplitude_mv_reg <= AMP_W'(3300);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FREQ_STEP:    freq_step_reg    <= cfg_data;
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[PHASE_W-1:0];
                REG_AMPLITUDE_MV: amplitude_mv_reg <= cfg_data[AMP_W-1:0];
                REG_UNUSED:       ;
            endcase
        end
    end

    sdsg_phase u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .sample_index (sample_index),
        .freq_step    (freq_step_reg),
        .phase_offset (phase_offset_reg),
        .out_valid    (ph_valid),
        .out_phase    (ph_data)
    );

    sdsg_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_phase  (ph_data),
        .out_valid (lk_valid),
        .level     (lk_level)
    );

    sdsg_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (lk_valid),
        .level        (lk_level),
        .amplitude_mv (amplitude_mv_reg),
        .out_valid    (done),
        .dac_code     (dac_code),
        .clipped      (clipped)
    );

endmodule

/* design/sdsg_phase.sv */
// ----------------------------------------------------------------------------
// sdsg_phase
// Two stages: index times frequency step, then scale, offset and split phase.
// ----------------------------------------------------------------------------
module sdsg_phase (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sdsg_pkg::IDX_W-1:0]   sample_index,
    input  logic [sdsg_pkg::FREQ_W-1:0]  freq_step,
    input  logic [sdsg_pkg::PHASE_W-1:0] phase_offset,
    output logic                         out_valid,
    output sdsg_pkg::phase_t             out_phase
);
    import sdsg_pkg::*;

    logic                  s1_valid_reg;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic [PROD_W-1:0]     s1_prod_next;
    logic                  s2_valid_reg;
    phase_t                s2_phase_reg;
    phase_t                s2_phase_next;
    logic [PHASE_W-1:0]    phase;

    assign s1_prod_next = PROD_W'(sample_index) * PROD_W'(freq_step);
    assign phase        = s1_prod_reg[TBL_SHIFT +: PHASE_W] + phase_offset;

    always_comb
    begin
        s2_phase_next.quad = phase[PHASE_W-1 -: 2];
        s2_phase_next.k    = phase[PHASE_W-3 -: QBITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg  <= s1_prod_next;
        s2_phase_reg <= s2_phase_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_phase = s2_phase_reg;

endmodule

/* design/sdsg_lookup.sv */
// ----------------------------------------------------------------------------
// sdsg_lookup
// Quarter-wave sine lookup with quadrant folding, offset to unsigned level.
// ----------------------------------------------------------------------------
module sdsg_lookup (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  sdsg_pkg::phase_t          in_phase,
    output logic                      out_valid,
    output logic [sdsg_pkg::V_W-1:0]  level
);
    import sdsg_pkg::*;

    logic [SINE_W-1:0] sine_rom [QUARTER_ENTRIES+1];
    logic [ROM_AW-1:0] addr;
    logic [SINE_W-1:0] mag;
    logic              valid_reg;
    logic [V_W-1:0]    level_reg;
    logic [V_W-1:0]    level_next;

    for (genvar g = 0; g <= QUARTER_ENTRIES; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    always_comb
    begin
        if (in_phase.quad[0])
        begin
            addr = ROM_AW'(QUARTER_ENTRIES) - ROM_AW'(in_phase.k);
        end
        else
        begin
            addr = ROM_AW'(in_phase.k);
        end
        mag = sine_rom[addr];
        if (in_phase.quad[1])
        begin
            level_next = V_W'(ONE_Q14) - V_W'(mag);
        end
        else
        begin
            level_next = V_W'(ONE_Q14) + V_W'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    assign out_valid = valid_reg;
    assign level     = level_reg;

endmodule

/* design/sdsg_scale.sv */
// ----------------------------------------------------------------------------
// sdsg_scale
// Amplitude scaling to DAC code: multiply, divide by 6600 * 2^14, saturate.
// ----------------------------------------------------------------------------
module sdsg_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sdsg_pkg::V_W-1:0]      level,
    input  logic [sdsg_pkg::AMP_W-1:0]    amplitude_mv,
    output logic                          out_valid,
    output logic [sdsg_pkg::CODE_W-1:0]   dac_code,
    output logic                          clipped
);
    import sdsg_pkg::*;

    logic              s4_valid_reg;
    logic [Y_W-1:0]    s4_y_reg;
    logic              s5_valid_reg;
    logic [X_W-1:0]    s5_x_reg;
    logic [X_W-1:0]    s5_x_next;
    logic [Z_W-1:0]    z;
    logic              s6_valid_reg;
    logic [X_W-1:0]    s6_x_reg;
    logic [Q_W-1:0]    s6_q_reg;
    logic [RP_W-1:0]   recip_prod;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic              clip_reg;
    logic              clip_next;
    logic [X_W-1:0]    rem;
    logic [Q_W-1:0]    quot;

    // y * 4095 = y * 4096 - y; drop the 2^17 factor of the divisor
    assign z         = {s4_y_reg, 12'd0} - Z_W'(s4_y_reg);
    assign s5_x_next = z[Z_W-1 -: X_W];
    assign recip_prod = RP_W'(s5_x_reg) * RP_W'(RECIP_825);

    always_comb
    begin
        rem  = s6_x_reg - X_W'(s6_q_reg) * X_W'(DIV_825);
        quot = (rem >= X_W'(DIV_825)) ? s6_q_reg + Q_W'(1) : s6_q_reg;
        if (quot > Q_W'(CODE_MAX))
        begin
            code_next = CODE_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            code_next = quot[CODE_W-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg  <= in_valid;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_y_reg <= Y_W'(level) * Y_W'(amplitude_mv);
        s5_x_reg <= s5_x_next;
        s6_x_reg <= s5_x_reg;
        s6_q_reg <= recip_prod[RECIP_SHIFT +: Q_W];
        code_reg <= code_next;
        clip_reg <= clip_next;
    end

    assign out_valid = out_valid_reg;
    assign dac_code  = code_reg;
    assign clipped   = clip_reg;

endmodule

/* design/sdsg_checker.sv */
// ----------------------------------------------------------------------------
// sdsg_checker
// Port-level checks of the sine DAC generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "sine_dac_sample_generator_macros.svh"

module sdsg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [sdsg_pkg::CODE_W-1:0]  dac_code,
    input logic                         clipped,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);
    import sdsg_pkg::*;

    // each transaction yields exactly one result after the pipeline delay
    `SDSG_ASSERT_DLY(a_result_follows, clk, rst_n, start && !busy, 7, done)
    `SDSG_ASSERT_IMP(a_no_orphan_result, clk, rst_n, done, $past(start && !busy, LATENCY))
    `SDSG_ASSERT_IMP(a_clip_saturates, clk, rst_n, done && clipped, dac_code == CODE_MAX)
    `SDSG_ASSERT_IMP(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind sine_dac_sample_generator sdsg_checker u_sdsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .dac_code  (dac_code),
    .clipped   (clipped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
